// File: design/cacs_pkg.sv
// ----------------------------------------------------------------------------
// Command sequencer package
// Shared constants, codes and types of the command, acknowledge and credit
// sequencer.
// ----------------------------------------------------------------------------
package cacs_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] MAX_QUERY_RETRIES = 3'd3;
	localparam logic [31:0] TIMEOUT_RESET = 32'd3000;

	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_ENQUEUE = 2'd1;
	localparam logic [1:0] MODE_RESP    = 2'd2;
	localparam logic [1:0] MODE_LINK    = 2'd3;

	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_SEND_QUERY = 3'd1;
	localparam logic [2:0] PH_WAIT_QUERY = 3'd2;
	localparam logic [2:0] PH_SEND_CMD   = 3'd3;
	localparam logic [2:0] PH_WAIT_CMD   = 3'd4;

	localparam logic [1:0] KIND_QUERY = 2'd0;
	localparam logic [1:0] KIND_CMD   = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;
	localparam logic [1:0] ST_ABORT   = 2'd3;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUERY_ID = 2'd1;

	typedef struct packed {
		logic [7:0] tag;
		logic       queued;
		logic [7:0] cmd_id;
	} entry_t;

	typedef struct packed {
		logic   push;
		logic   pop;
		logic   clear;
		entry_t wdata;
	} fifo_ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		entry_t           head;
	} fifo_sts_t;

endpackage

// File: design/cacs_if.sv
// ----------------------------------------------------------------------------
// Command sequencer channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface cacs_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  cmd_id;
	logic        queued_flag;
	logic [7:0]  tag;
	logic [7:0]  resp_id;
	logic [31:0] resp_credit;
	logic        link_up;

	modport source (output valid, mode, cmd_id, queued_flag, tag, resp_id, resp_credit,
		link_up, input ready);
	modport sink (input valid, mode, cmd_id, queued_flag, tag, resp_id, resp_credit,
		link_up, output ready);
endinterface

interface cacs_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_tag;
	logic [7:0] out_cmd_id;
	logic [1:0] status;
	logic       last;

	modport source (output valid, kind, out_tag, out_cmd_id, status, last, input ready);
	modport sink (input valid, kind, out_tag, out_cmd_id, status, last, output ready);
endinterface

interface cacs_cfg_if import cacs_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/command_ack_credit_sequencer_top.sv
// ----------------------------------------------------------------------------
// Command, acknowledge and credit sequencer
// Sends pending commands to a link partner one at a time, with credit queries,
// acknowledgement matching, timeouts and a disconnect flush.
// ----------------------------------------------------------------------------
// The item channel carries ticks, enqueued commands, arrived responses and
// link status changes. The result channel carries query sends, command sends
// and completions; last marks the final beat of each input item. Registers
// are written through the cfg channel, which is always ready.
// An item is accepted in the idle state and then executed against the head
// entry, which the queue memory has already read out. A disconnect with
// pending entries gives one beat per entry as the flush walks the memory
// from the head.
// A finished beat sits in an output register, so execution continues while
// it waits. When the receiver stalls and the output register is full, the
// execute or flush cycle repeats until the beat can be taken; no state
// changes in the meantime. Reset empties the queue, disconnects the link,
// clears credit and the timer, and loads the register defaults.
// ----------------------------------------------------------------------------
module command_ack_credit_sequencer_top import cacs_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	cacs_item_if.sink      item,
	cacs_result_if.source  result,
	cacs_cfg_if.sink       cfg
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_FLUSH = 2'd2;

	logic [1:0]  st_q, st_d;
	logic [31:0] timeout_q;
	logic [7:0]  qid_q;
	logic [2:0]  phase_q, phase_d;
	logic [31:0] credit_q, credit_d;
	logic [31:0] wait_q, wait_d;
	logic [2:0]  retries_q, retries_d;
	logic        resp_pend_q, resp_pend_d;
	logic [7:0]  resp_id_q;
	logic [31:0] resp_cred_q;
	logic        link_q, link_d;
	logic        latch_resp;

	logic [1:0]  mode_q;
	logic [7:0]  cid_q;
	logic        qf_q;
	logic [7:0]  tag_q;
	logic [7:0]  rid_in_q;
	logic [31:0] rcred_in_q;
	logic        link_up_q;

	logic        res_v_q;
	logic [1:0]  res_kind_q;
	logic [7:0]  res_tag_q;
	logic [7:0]  res_id_q;
	logic [1:0]  res_status_q;
	logic        res_last_q;

	fifo_ctl_t   fctl;
	fifo_sts_t   fsts;
	entry_t      head;

	logic        slot_free;
	logic        emit;
	logic        commit;
	logic [1:0]  e_kind;
	logic [7:0]  e_tag;
	logic [7:0]  e_id;
	logic [1:0]  e_status;
	logic        e_last;
	logic        pop_req;
	logic [2:0]  ph;
	logic [31:0] wait_inc;
	logic        expired;

	cacs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fctl),
		.sts    (fsts)
	);

	assign head       = fsts.head;
	assign slot_free  = !res_v_q || result.ready;
	assign item.ready = (st_q == S_IDLE);
	assign cfg.ready  = 1'b1;

	assign wait_inc = (wait_q == '1) ? wait_q : wait_q + 32'd1;
	assign expired  = wait_inc > timeout_q;

	always_comb begin
		st_d        = st_q;
		phase_d     = phase_q;
		credit_d    = credit_q;
		wait_d      = wait_q;
		retries_d   = retries_q;
		resp_pend_d = resp_pend_q;
		link_d      = link_q;
		latch_resp  = 1'b0;
		emit        = 1'b0;
		pop_req     = 1'b0;
		e_kind      = KIND_DONE;
		e_tag       = head.tag;
		e_id        = head.cmd_id;
		e_status    = ST_OK;
		e_last      = 1'b1;
		ph          = phase_q;
		fctl        = '0;
		fctl.wdata  = '{tag: tag_q, queued: qf_q, cmd_id: cid_q};
		commit      = 1'b0;

		unique case (st_q)
			S_IDLE: begin
				if (item.valid) begin
					st_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (mode_q)
					MODE_TICK: begin
						if (link_q) begin
							if (fsts.count == '0) begin
								phase_d   = PH_IDLE;
								retries_d = '0;
							end else begin
								if (phase_q == PH_IDLE) begin
									retries_d = '0;
									ph = (head.queued && credit_q == '0) ? PH_SEND_QUERY
										: PH_SEND_CMD;
								end
								case (ph)
									PH_SEND_QUERY: begin
										resp_pend_d = 1'b0;
										emit        = 1'b1;
										e_kind      = KIND_QUERY;
										e_id        = qid_q;
										phase_d     = PH_WAIT_QUERY;
										wait_d      = '0;
									end
									PH_SEND_CMD: begin
										resp_pend_d = 1'b0;
										emit        = 1'b1;
										e_kind      = KIND_CMD;
										phase_d     = PH_WAIT_CMD;
										wait_d      = '0;
									end
									PH_WAIT_QUERY: begin
										if (resp_pend_q) begin
											if (resp_id_q != qid_q) begin
												phase_d = PH_SEND_QUERY;
											end else begin
												credit_d = resp_cred_q;
												if (resp_cred_q == '0) begin
													pop_req  = 1'b1;
													e_status = ST_FULL;
													phase_d  = PH_IDLE;
												end else begin
													phase_d = PH_SEND_CMD;
												end
											end
										end else begin
											wait_d = wait_inc;
											if (expired) begin
												retries_d = retries_q + 3'd1;
												if (retries_q >= MAX_QUERY_RETRIES) begin
													pop_req  = 1'b1;
													e_status = ST_TIMEOUT;
													phase_d  = PH_IDLE;
												end else begin
													phase_d = PH_SEND_QUERY;
												end
											end
										end
									end
									PH_WAIT_CMD: begin
										if (resp_pend_q) begin
											if (resp_id_q != head.cmd_id) begin
												phase_d = PH_SEND_CMD;
											end else begin
												if (head.queued && credit_q != '0) begin
													credit_d = credit_q - 32'd1;
												end
												pop_req = 1'b1;
												phase_d = PH_IDLE;
											end
										end else begin
											wait_d = wait_inc;
											if (expired) begin
												pop_req  = 1'b1;
												e_status = ST_TIMEOUT;
												phase_d  = PH_IDLE;
											end
										end
									end
									default: begin
										phase_d = PH_IDLE;
									end
								endcase
								if (pop_req) begin
									emit = 1'b1;
								end
							end
						end
					end
					MODE_ENQUEUE: begin
						if (fsts.count == CNT_W'(QUEUE_DEPTH)) begin
							emit     = 1'b1;
							e_tag    = tag_q;
							e_id     = cid_q;
							e_status = ST_FULL;
						end else begin
							fctl.push = 1'b1;
						end
					end
					MODE_RESP: begin
						latch_resp  = 1'b1;
						resp_pend_d = 1'b1;
					end
					default: begin
						link_d   = link_up_q;
						credit_d = '0;
						if (!link_up_q) begin
							phase_d = PH_IDLE;
							if (fsts.count != '0) begin
								st_d = S_FLUSH;
							end else begin
								fctl.clear = 1'b1;
							end
						end
					end
				endcase
				commit = !emit || slot_free;
				if (commit) begin
					if (st_d == S_EXEC) begin
						st_d = S_IDLE;
					end
					fctl.pop = pop_req;
				end else begin
					st_d        = S_EXEC;
					phase_d     = phase_q;
					credit_d    = credit_q;
					wait_d      = wait_q;
					retries_d   = retries_q;
					resp_pend_d = resp_pend_q;
					link_d      = link_q;
					fctl.push   = 1'b0;
					fctl.clear  = 1'b0;
				end
			end
			S_FLUSH: begin
				if (fsts.count == '0) begin
					fctl.clear = 1'b1;
					st_d       = S_IDLE;
				end else if (slot_free) begin
					emit     = 1'b1;
					e_status = ST_ABORT;
					e_last   = (fsts.count == CNT_W'(1));
					fctl.pop = 1'b1;
					commit   = 1'b1;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			timeout_q   <= TIMEOUT_RESET;
			qid_q       <= '0;
			phase_q     <= PH_IDLE;
			credit_q    <= '0;
			wait_q      <= '0;
			retries_q   <= '0;
			resp_pend_q <= 1'b0;
			resp_id_q   <= '0;
			resp_cred_q <= '0;
			link_q      <= 1'b0;
			res_v_q     <= 1'b0;
		end else begin
			st_q        <= st_d;
			phase_q     <= phase_d;
			credit_q    <= credit_d;
			wait_q      <= wait_d;
			retries_q   <= retries_d;
			resp_pend_q <= resp_pend_d;
			link_q      <= link_d;
			if (latch_resp) begin
				resp_id_q   <= rid_in_q;
				resp_cred_q <= rcred_in_q;
			end
			if (cfg.valid) begin
				case (cfg.index)
					CFG_TIMEOUT:  timeout_q <= cfg.data;
					CFG_QUERY_ID: qid_q     <= cfg.data[7:0];
					default: ;
				endcase
			end
			if (emit && commit) begin
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			mode_q     <= item.mode;
			cid_q      <= item.cmd_id;
			qf_q       <= item.queued_flag;
			tag_q      <= item.tag;
			rid_in_q   <= item.resp_id;
			rcred_in_q <= item.resp_credit;
			link_up_q  <= item.link_up;
		end
		if (emit && commit) begin
			res_kind_q   <= e_kind;
			res_tag_q    <= e_tag;
			res_id_q     <= e_id;
			res_status_q <= e_status;
			res_last_q   <= e_last;
		end
	end

	assign result.valid      = res_v_q;
	assign result.kind       = res_kind_q;
	assign result.out_tag    = res_tag_q;
	assign result.out_cmd_id = res_id_q;
	assign result.status     = res_status_q;
	assign result.last       = res_last_q;

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FLUSH && st_d == S_IDLE) |-> fsts.count == '0)
		else $error("flush ended with entries pending");

	a_beat_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_v_q) |-> $past(st_q) != S_IDLE)
		else $error("result beat raised outside execute or flush");

	a_no_tick_offline: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EXEC && mode_q == MODE_TICK && !link_q) |-> !emit)
		else $error("tick produced a beat while disconnected");

endmodule

// File: design/cacs_fifo.sv
// ----------------------------------------------------------------------------
// Pending command queue
// Synchronous memory of pending commands with head and tail pointers. The
// read port follows the next head pointer, so the registered head entry
// follows each pop or clear.
// ----------------------------------------------------------------------------
module cacs_fifo import cacs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  fifo_ctl_t ctl,
	output fifo_sts_t sts
);

	entry_t           mem [QUEUE_DEPTH];
	entry_t           rd_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] head_d;
	logic [PTR_W-1:0] tail_d;
	logic [CNT_W-1:0] count_q;

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		if (ctl.clear) begin
			head_d = '0;
			tail_d = '0;
		end else begin
			if (ctl.pop) begin
				head_d = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (ctl.push) begin
				tail_d = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= ctl.wdata;
		end
		rd_q <= mem[head_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			if (ctl.push && !ctl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop && !ctl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign sts = '{count: count_q, head: rd_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> count_q != CNT_W'(QUEUE_DEPTH))
		else $error("push into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> count_q != '0)
		else $error("pop from an empty queue");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> head_q == tail_q && count_q == '0)
		else $error("pointer clear left entries behind");

endmodule
